[rtl/aes128_block_cipher_core_macros.svh]
// Assertion macros for the AES-128 core.
`ifndef AES128_BLOCK_CIPHER_CORE_MACROS_SVH
`define AES128_BLOCK_CIPHER_CORE_MACROS_SVH
// Assert an implication on the rising clock edge, skipped in reset.
`define AES_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Assert a next-cycle implication on the rising clock edge, skipped in reset.
`define AES_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

[rtl/aes_pkg.sv]
// Package for the AES-128 core: types, constants and byte-level functions.
`default_nettype none
package aes_pkg;

    localparam int unsigned NumRounds    = 10;
    localparam int unsigned NumRoundKeys = NumRounds + 1;
    localparam int unsigned NumKeyWords  = 44;
    localparam int unsigned KeyIdxW      = 6;
    localparam int unsigned RoundW       = 4;

    typedef enum logic [1:0] {
        ST_EXPAND,
        ST_IDLE,
        ST_ROUND,
        ST_OUT
    } aes_state_t;

    typedef enum logic [0:0] {
        REG_KEY_HIGH = 1'b0,
        REG_KEY_LOW  = 1'b1
    } aes_reg_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // multiply by x in GF(2^8)
    function automatic logic [7:0] xt(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // forward column mix
    function automatic logic [31:0] mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3;
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
    endfunction

    // inverse column mix: premultiply by {04}x^2+{05}, then forward mix
    function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3, u, v;
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        u = xt(xt(a0 ^ a2));
        v = xt(xt(a1 ^ a3));
        return mix_col({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
    endfunction

endpackage
`default_nettype wire

[rtl/aes128_block_cipher_core.sv]
// AES-128 encrypt/decrypt core, one round per cycle on a shared round unit.
//
// Input stream: s_tdata carries one 128-bit block, s_tuser the direction
// (0 encrypt, 1 decrypt). Result stream: m_tdata carries the 128-bit result.
// The user writes the key through cfg_we/cfg_index/cfg_wdata (0 key high,
// 1 key low) only while the core is idle; the core does not enforce this. Each
// write restarts the key expansion, one round-key word per cycle, s_tready low.
// After reset the schedule of the all-zero key is built the same way.
// The initial key add happens at the accepting edge, then the ten rounds
// follow, each registered in st_reg; m_tvalid rises after the last round.
// A block passes through accept, ten rounds and the result state; the shared
// round unit and the rule that a new block waits for the previous result
// keep the core from taking a new block before the last one is delivered.
// A stalled receiver holds m_tvalid and m_tdata unless cfg_we is raised; no new
// block is taken until the result has been delivered.
`default_nettype none
`include "aes128_block_cipher_core_macros.svh"
module aes128_block_cipher_core (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [0:0]   cfg_index,
    input  wire logic [63:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // [63:0] block_high, [127:64] block_low
    input  wire logic         s_tuser,   // direction
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata    // [63:0] out_high, [127:64] out_low
);
    import aes_pkg::*;

    aes_state_t state_reg, state_next;
    logic [63:0]  key_hi_reg, key_lo_reg;
    logic [127:0] rk_mem [NumRoundKeys];              // round keys 1..10; round 0 is the key
    logic [KeyIdxW-1:0] kidx_reg, kidx_next;
    logic [31:0]  w1_reg, w2_reg, w3_reg, w4_reg;   // sliding window of last four words
    logic [7:0]   rcon_reg;
    logic [RoundW-1:0] rnd_reg, rnd_next;
    logic [RoundW-1:0] krnd;
    logic         dir_reg;
    logic [127:0] st_reg;
    logic [127:0] rk_q_reg;                           // round key read for next round
    logic [127:0] key_now;
    logic [31:0]  new_word;

    // key expansion word from the window
    always_comb begin
        logic [31:0] t;
        t = w4_reg;
        if (kidx_reg[1:0] == 2'd0)
            t = sub_word({w4_reg[23:0], w4_reg[31:24]}) ^ {rcon_reg, 24'h0};
        new_word = w1_reg ^ t;
    end

    // round-key memory: one word lane written per expansion cycle
    always_ff @(posedge aclk) begin
        if (state_reg == ST_EXPAND && kidx_reg < KeyIdxW'(NumKeyWords))
            rk_mem[kidx_reg[KeyIdxW-1:2]][127-32*kidx_reg[1:0] -: 32] <= new_word;
    end

    // round key of the next round step (direction aware), registered
    always_comb begin
        krnd = dir_reg ? RoundW'(NumRounds) - rnd_next : rnd_next;
        if (state_reg == ST_IDLE) krnd = s_tuser ? RoundW'(NumRounds - 1) : RoundW'(1);
    end
    always_ff @(posedge aclk) begin
        rk_q_reg <= (krnd == '0) ? key_now : rk_mem[krnd];
    end

    // shared round unit
    logic [127:0] in_blk, rnd_out;
    assign in_blk = {s_tdata[63:0], s_tdata[127:64]};
    always_comb begin
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic last;
        last = (rnd_reg == RoundW'(NumRounds));
        for (int i = 0; i < 16; i++) b[i] = st_reg[127-8*i -: 8];
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                t[4*c+r] = dir_reg ? INV_SBOX[b[4*((c-r+4)%4)+r]] : SBOX[b[4*((c+r)%4)+r]];
        for (int c = 0; c < 4; c++) begin
            logic [31:0] col;
            col = {t[4*c], t[4*c+1], t[4*c+2], t[4*c+3]} ^
                  (dir_reg ? rk_q_reg[127-32*c -: 32] : 32'h0);
            if (!last) col = dir_reg ? inv_mix_col(col) : mix_col(col);
            if (!dir_reg) col = col ^ rk_q_reg[127-32*c -: 32];
            rnd_out[127-32*c -: 32] = col;
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        kidx_next  = kidx_reg;
        rnd_next   = rnd_reg;
        unique case (state_reg)
            ST_EXPAND: begin
                kidx_next = kidx_reg + KeyIdxW'(1);
                if (kidx_reg == KeyIdxW'(NumKeyWords - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                // first round step follows the accepting edge
                rnd_next = RoundW'(1);
                if (s_tvalid) state_next = ST_ROUND;
            end
            ST_ROUND: begin
                if (rnd_reg == RoundW'(NumRounds)) state_next = ST_OUT;
                else rnd_next = rnd_reg + RoundW'(1);
            end
            ST_OUT: begin
                if (m_tready) state_next = ST_IDLE;
                rnd_next = RoundW'(0);
            end
            default: state_next = ST_IDLE;
        endcase
        if (cfg_we) begin
            state_next = ST_EXPAND;
            kidx_next  = KeyIdxW'(4);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_EXPAND;
            kidx_reg  <= KeyIdxW'(4);
            rnd_reg   <= '0;
            key_hi_reg <= '0;
            key_lo_reg <= '0;
            rcon_reg  <= 8'h01;
            w1_reg <= '0; w2_reg <= '0; w3_reg <= '0; w4_reg <= '0;
        end else begin
            state_reg <= state_next;
            kidx_reg  <= kidx_next;
            rnd_reg   <= rnd_next;
            if (cfg_we) begin
                unique case (aes_reg_t'(cfg_index))
                    REG_KEY_HIGH: begin
                        key_hi_reg <= cfg_wdata;
                        w1_reg <= cfg_wdata[63:32]; w2_reg <= cfg_wdata[31:0];
                        w3_reg <= key_lo_reg[63:32]; w4_reg <= key_lo_reg[31:0];
                    end
                    REG_KEY_LOW: begin
                        key_lo_reg <= cfg_wdata;
                        w1_reg <= key_hi_reg[63:32]; w2_reg <= key_hi_reg[31:0];
                        w3_reg <= cfg_wdata[63:32]; w4_reg <= cfg_wdata[31:0];
                    end
                    default: ;
                endcase
                rcon_reg <= 8'h01;
            end else if (state_reg == ST_EXPAND) begin
                w1_reg <= w2_reg; w2_reg <= w3_reg; w3_reg <= w4_reg; w4_reg <= new_word;
                if (kidx_reg[1:0] == 2'd0) rcon_reg <= xt(rcon_reg);
            end
        end
    end

    // first four words live in the key registers; rest in memory
    assign key_now = {key_hi_reg, key_lo_reg};

    // datapath
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            dir_reg <= s_tuser;
            st_reg  <= in_blk ^ (s_tuser ? rk_mem[RoundW'(NumRounds)] : key_now);
        end else if (state_reg == ST_ROUND) begin
            st_reg <= rnd_out;
        end
    end

    assign s_tready = (state_reg == ST_IDLE) && !cfg_we;
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {st_reg[63:0], st_reg[127:64]};

    `AES_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready && !cfg_we, m_tvalid, "result dropped")
    `AES_ASSERT_IMPL(a_excl, aclk, aresetn, m_tvalid, !s_tready, "ready while result pending")
    `AES_ASSERT_IMPL(a_rnd, aclk, aresetn, state_reg == ST_ROUND, rnd_reg != '0, "bad round")
endmodule
`default_nettype wire
